@@ design/uab_pkg.sv @@
// Shared constants, register codes and beat types for the UART autobaud bit-width block.
package uab_pkg;

	localparam int unsigned PULSE_BITS       = 20;
	localparam int unsigned MAX_MULTIPLE_DEF = 9;
	localparam int unsigned EDGE_BITS        = 10;
	localparam int unsigned APB_BITS         = 28;
	localparam int unsigned WIDTH_BITS       = 20;
	localparam int unsigned TOL_DIV          = 10;
	localparam int unsigned CFG_IDX_BITS     = 1;

	localparam logic [EDGE_BITS-1:0] MIN_EDGES_RST = EDGE_BITS'(10);
	localparam logic [APB_BITS-1:0]  APB_CLOCK_RST = APB_BITS'(80000000);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MIN_EDGES = 1'b0,
		REG_APB_CLOCK = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [EDGE_BITS-1:0]  edge_count;
		logic [PULSE_BITS-1:0] low_pulse_min;
		logic [PULSE_BITS-1:0] high_pulse_min;
	} meas_t;

	typedef struct packed {
		logic                  found;
		logic [WIDTH_BITS-1:0] bit_clocks;
		logic [APB_BITS-1:0]   baud_rate;
	} res_t;

	typedef struct packed {
		logic                  found;
		logic [PULSE_BITS-1:0] bit_clocks;
	} wbeat_t;

endpackage

@@ design/uab_front.sv @@
// Five-stage front end: pulse ordering, tolerance, multiple match and bit-width estimate.
module uab_front import uab_pkg::*; #(
	parameter int unsigned MAX_MULTIPLE = MAX_MULTIPLE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  meas_t                meas,
	input  logic [EDGE_BITS-1:0] min_edges,
	output logic                 out_valid,
	output wbeat_t               out
);

	localparam int unsigned PB = PULSE_BITS;
	localparam int unsigned MB = $clog2(MAX_MULTIPLE + 1);
	localparam int unsigned LW = PB + MB;
	localparam int unsigned RS = PB + 4;
	localparam int unsigned RW = RS + 1;
	localparam logic [RW-1:0] TOL_RCP =
		RW'(((64'd1 << RS) + 64'(TOL_DIV) - 64'd1) / 64'(TOL_DIV));

	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic          eok_s1, eok_s2, eok_s3;
	logic [PB-1:0] l_s1, h_s1, l_s2, h_s2, l_s3, h_s3, l_s4;
	logic [PB-1:0] tol_s2;
	logic [LW-1:0] lm_s2 [MAX_MULTIPLE];
	logic          hit_s3;
	logic [RW-1:0] rcp_s3;
	logic          found_s4, found_s5;
	logic [PB-1:0] q_s4, width_s5;

	logic          lo_less;
	logic [PB-1:0] l_c, h_c;
	logic [PB+RW-1:0] tol_prod, q_prod;
	logic [LW-1:0] lm_c [MAX_MULTIPLE];
	logic [RW-1:0] rcp_c [MAX_MULTIPLE];
	logic [MAX_MULTIPLE-1:0] hit_c;
	logic [RW-1:0] rcp_sel;
	logic [PB:0]   sum_c;

	assign lo_less = meas.low_pulse_min < meas.high_pulse_min;
	assign l_c     = lo_less ? meas.low_pulse_min : meas.high_pulse_min;
	assign h_c     = lo_less ? meas.high_pulse_min : meas.low_pulse_min;

	assign tol_prod = {{RW{1'b0}}, l_s1} * {{PB{1'b0}}, TOL_RCP};

	for (genvar gk = 0; gk < MAX_MULTIPLE; gk++) begin : g_lane
		localparam int unsigned M = gk + 1;
		localparam logic [RW-1:0] RCP = RW'(((64'd1 << RS) + 64'(M) - 64'd1) / 64'(M));
		logic [LW-1:0] hx, gap;

		assign lm_c[gk]  = LW'(l_s1) * LW'(M);
		assign rcp_c[gk] = RCP;
		assign hx        = LW'(h_s2);
		assign gap       = (hx > lm_s2[gk]) ? (hx - lm_s2[gk]) : (lm_s2[gk] - hx);
		assign hit_c[gk] = gap < LW'(tol_s2);
	end

	always_comb begin
		rcp_sel = '0;
		for (int k = MAX_MULTIPLE - 1; k >= 0; k--) begin
			if (hit_c[k]) begin
				rcp_sel = rcp_c[k];
			end
		end
	end

	assign q_prod = {{RW{1'b0}}, h_s3} * {{PB{1'b0}}, rcp_s3};
	assign sum_c  = {1'b0, l_s4} + {1'b0, q_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eok_s1   <= meas.edge_count >= min_edges;
			l_s1     <= l_c;
			h_s1     <= h_c;

			eok_s2   <= eok_s1;
			l_s2     <= l_s1;
			h_s2     <= h_s1;
			tol_s2   <= tol_prod[RS +: PB];
			lm_s2    <= lm_c;

			eok_s3   <= eok_s2;
			hit_s3   <= |hit_c;
			l_s3     <= l_s2;
			h_s3     <= h_s2;
			rcp_s3   <= rcp_sel;

			found_s4 <= hit_s3 && eok_s3;
			l_s4     <= l_s3;
			q_s4     <= q_prod[RS +: PB];

			found_s5 <= found_s4;
			width_s5 <= found_s4 ? sum_c[PB:1] : '0;
		end
	end

	assign out_valid      = v_s5;
	assign out.found      = found_s5;
	assign out.bit_clocks = width_s5;

endmodule

@@ design/uab_div.sv @@
// Pipelined restoring divider, one quotient bit per stage: bus clock over bit width.
module uab_div import uab_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  wbeat_t              in_beat,
	input  logic [APB_BITS-1:0] apb_clock_hz,
	output logic                out_valid,
	output res_t                out
);

	localparam int unsigned PB = PULSE_BITS;
	localparam int unsigned QB = APB_BITS;

	logic          v_s   [QB];
	logic          f_s   [QB];
	logic [PB-1:0] rem_s [QB];
	logic [PB-1:0] d_s   [QB];
	logic [QB-1:0] dq_s  [QB];

	for (genvar gi = 0; gi < QB; gi++) begin : g_step
		logic          pv, pf;
		logic [PB-1:0] prem, pd;
		logic [QB-1:0] pdq;
		logic [PB:0]   trial;
		logic          take;

		if (gi == 0) begin : g_head
			assign pv   = in_valid;
			assign pf   = in_beat.found;
			assign prem = '0;
			assign pd   = in_beat.bit_clocks;
			assign pdq  = apb_clock_hz;
		end else begin : g_body
			assign pv   = v_s[gi-1];
			assign pf   = f_s[gi-1];
			assign prem = rem_s[gi-1];
			assign pd   = d_s[gi-1];
			assign pdq  = dq_s[gi-1];
		end

		assign trial = {prem, pdq[QB-1]};
		assign take  = trial >= {1'b0, pd};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[gi] <= 1'b0;
			end else if (en) begin
				v_s[gi] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				f_s[gi]   <= pf;
				d_s[gi]   <= pd;
				rem_s[gi] <= take ? PB'(trial - {1'b0, pd}) : trial[PB-1:0];
				dq_s[gi]  <= {pdq[QB-2:0], take};
			end
		end
	end

	assign out_valid      = v_s[QB-1];
	assign out.found      = f_s[QB-1];
	assign out.bit_clocks = WIDTH_BITS'(d_s[QB-1]);
	assign out.baud_rate  = f_s[QB-1] ? dq_s[QB-1] : '0;

endmodule

@@ design/uart_autobaud_bit_width.sv @@
// Top level of the UART autobaud bit-width and baud-rate calculator.
// Each accepted measurement passes the front end, then the baud divider, to its result beat.
// Throughput: one measurement per cycle unless stalled; one quotient bit per divider stage.
// A stalled result beat holds every stage and stalls the measurement channel.
// Reset clears all valid bits and loads min_edges = 10 and apb_clock_hz = 80000000.
module uart_autobaud_bit_width import uab_pkg::*; #(
	parameter int unsigned MAX_MULTIPLE = MAX_MULTIPLE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [APB_BITS-1:0]     cfg_data,
	input  logic                    meas_valid,
	output logic                    meas_stall,
	input  meas_t                   meas,
	output logic                    res_valid,
	input  logic                    res_stall,
	output res_t                    res
);

	logic [EDGE_BITS-1:0] min_edges_q;
	logic [APB_BITS-1:0]  apb_clock_hz_q;
	logic                 en;
	logic                 wv;
	wbeat_t               wbeat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_edges_q    <= MIN_EDGES_RST;
			apb_clock_hz_q <= APB_CLOCK_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_EDGES: min_edges_q    <= cfg_data[EDGE_BITS-1:0];
				REG_APB_CLOCK: apb_clock_hz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en         = !(res_valid && res_stall);
	assign meas_stall = !en;

	uab_front #(
		.MAX_MULTIPLE(MAX_MULTIPLE)
	) front_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (meas_valid),
		.meas      (meas),
		.min_edges (min_edges_q),
		.out_valid (wv),
		.out       (wbeat)
	);

	uab_div div_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (wv),
		.in_beat      (wbeat),
		.apb_clock_hz (apb_clock_hz_q),
		.out_valid    (res_valid),
		.out          (res)
	);

endmodule

@@ design/uab_chk.sv @@
// Port-level checker for the autobaud block, bound to the top level.
module uab_chk import uab_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  meas_stall,
	input logic  res_valid,
	input logic  res_stall,
	input res_t  res
);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.found |-> res.bit_clocks == '0 && res.baud_rate == '0)
		else $error("not-found beat carries nonzero width or baud");

	a_found_width: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.found |-> res.bit_clocks >= WIDTH_BITS'(TOL_DIV / 2))
		else $error("found beat with implausibly small bit width");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> meas_stall)
		else $error("measurement taken while result beat is stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result beat changed");

endmodule

bind uart_autobaud_bit_width uab_chk chk_i (
	.clk        (clk),
	.arst_n     (arst_n),
	.meas_stall (meas_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);
